[hw/rtl/reprojection_error_jacobian_unit_defines.svh]
// Assertion macros for the reprojection error and Jacobian unit.
`ifndef REPROJECTION_ERROR_JACOBIAN_UNIT_DEFINES_SVH
`define REPROJECTION_ERROR_JACOBIAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define REJ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reprojection unit: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define REJ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reprojection unit: check failed");

`else

`define REJ_ASSERT_NOW(lbl, ante, cons)
`define REJ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/rej_pkg.sv]
// Shared types, constants and saturation helper for the reprojection unit.
`default_nettype none

package rej_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 31;
    localparam int DIV_W      = DATA_W + FRAC_BITS;
    localparam int POSE_WORDS = 12;
    localparam int ROW_FIELDS = 10;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int STEP_W     = 6;
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = ROW_FIELDS * DATA_W;

    localparam logic ACTION_LOAD    = 1'b0;
    localparam logic ACTION_PROJECT = 1'b1;

    localparam logic [1:0] REG_FOCAL_X  = 2'd0;
    localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
    localparam logic [1:0] REG_CENTER_X = 2'd2;
    localparam logic [1:0] REG_CENTER_Y = 2'd3;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t SAT_MAX = 32'sh7fffffff;
    localparam word_t SAT_MIN = 32'sh80000000;
    localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic       action;
        logic [3:0] pose_index;
        word_t      pose_value;
        word_t      point_x;
        word_t      point_y;
        word_t      point_z;
        word_t      meas_u;
        word_t      meas_v;
    } item_t;

    typedef struct packed {
        word_t [ROW_FIELDS-1:0] u;
        word_t [ROW_FIELDS-1:0] v;
        logic                   inv;
    } rows_t;

    typedef struct packed {
        logic  load;
        rows_t rows;
    } hand_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MAC,
        BS_CHK,
        BS_DIV,
        BS_POST,
        BS_HAND
    } back_state_t;

    typedef enum logic [1:0] {
        OS_EMPTY,
        OS_U,
        OS_V
    } out_state_t;

    function automatic word_t sat64(input logic signed [63:0] v);
        word_t r;
        if (v > WIDE_MAX)
        begin
            r = SAT_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r = SAT_MIN;
        end
        else
        begin
            r = word_t'(v[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rej_front.sv]
// Input side: accept beats, unpack them and hold them in a short queue.
`default_nettype none

module rej_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rej_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tuser,
    output logic                                 q_valid,
    input  wire logic                            q_ready,
    output rej_pkg::item_t                       q_item
);
    import rej_pkg::*;

    item_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic                pop;
    item_t               in_item;

    always_comb
    begin
        in_item.action     = s_axis_tuser;
        in_item.pose_index = s_axis_tdata[3:0];
        in_item.pose_value = word_t'(s_axis_tdata[35:4]);
        in_item.point_x    = word_t'(s_axis_tdata[67:36]);
        in_item.point_y    = word_t'(s_axis_tdata[99:68]);
        in_item.point_z    = word_t'(s_axis_tdata[131:100]);
        in_item.meas_u     = word_t'(s_axis_tdata[163:132]);
        in_item.meas_v     = word_t'(s_axis_tdata[195:164]);
    end

    assign s_axis_tready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign q_valid       = (count_reg != '0);
    assign q_item        = mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rej_div.sv]
// Radix-2 restoring divider: sat(trunc(num * 2^FRAC / den)) for den > 0.
`default_nettype none

module rej_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rej_pkg::word_t num,
    input  wire rej_pkg::word_t den,
    output logic               done,
    output rej_pkg::word_t     quo
);
    import rej_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DATA_W:0]        rem_reg;
    logic [DIV_W-1:0]       dvd_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic                   neg_reg;
    logic [DATA_W-1:0]      den_reg;
    logic [DATA_W:0]        rem_sh;
    logic                   fits;
    logic [DATA_W:0]        rem_next;
    logic [DATA_W-1:0]      mag;
    logic signed [DIV_W:0]  sq;

    assign mag      = num[DATA_W-1] ? (~num + 1'b1) : num;
    assign rem_sh   = {rem_reg[DATA_W-1:0], dvd_reg[DIV_W-1]};
    assign fits     = (rem_sh >= {1'b0, den_reg});
    assign rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign sq       = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign quo      = sat64(64'(sq));
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= num[DATA_W-1];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rej_back.sv]
// Execution side: pose store, camera registers and the multiply-accumulate sequencer.
`default_nettype none

module rej_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [rej_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      q_valid,
    output logic                           q_ready,
    input  wire rej_pkg::item_t            q_item,
    input  wire logic                      out_free,
    output rej_pkg::hand_t                 hand
);
    import rej_pkg::*;

    typedef enum logic [4:0] {
        D_NONE, D_PC0, D_PC1, D_PC2, D_FXZ, D_FYY,
        D_M0, D_M1, D_M2, D_M3, D_M4, D_M5,
        D_U3, D_U4, D_U6, D_V3,
        D_U7, D_U8, D_U9, D_V7, D_V8, D_V9
    } dst_t;

    localparam word_t ONE = word_t'(1 << FRAC_BITS);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [1:0]         div_sel_reg;
    logic               div_wait_reg;
    logic [CFG_W-1:0]   fx_reg, fy_reg, cx_reg, cy_reg;
    word_t              pose_reg [POSE_WORDS];
    word_t              p_reg [3];
    word_t              mu_reg, mv_reg;
    word_t              pc_reg [3];
    word_t              xz_reg, yz_reg, iz_reg, fxz_reg, fyy_reg;
    word_t              m_reg [6];
    word_t              u_reg [ROW_FIELDS];
    word_t              v_reg [ROW_FIELDS];
    logic               inv_reg;
    logic signed [63:0] acc_reg;

    word_t              fx_w, fy_w;
    word_t              op_a, op_b, init_w;
    logic               first, last;
    dst_t               dst;
    logic signed [63:0] prod, acc_sum;
    word_t              acc_sat;
    logic               mac_en;
    logic               div_start;
    logic               div_done;
    word_t              div_num;
    word_t              div_quo;

    assign fx_w = word_t'({1'b0, fx_reg});
    assign fy_w = word_t'({1'b0, fy_reg});

    rej_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (pc_reg[2]),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        case (div_sel_reg)
            2'd0:    div_num = pc_reg[0];
            2'd1:    div_num = pc_reg[1];
            default: div_num = ONE;
        endcase
    end

    // Operand table of the shared multiplier.
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        init_w = '0;
        first  = 1'b1;
        last   = 1'b1;
        dst    = D_NONE;
        case (step_reg)
            6'd0:  begin op_a = pose_reg[0]; op_b = p_reg[0]; init_w = pose_reg[9]; last = 1'b0; end
            6'd1:  begin op_a = pose_reg[1]; op_b = p_reg[1]; first = 1'b0; last = 1'b0; end
            6'd2:  begin op_a = pose_reg[2]; op_b = p_reg[2]; first = 1'b0; dst = D_PC0; end
            6'd3:  begin op_a = pose_reg[3]; op_b = p_reg[0]; init_w = pose_reg[10]; last = 1'b0; end
            6'd4:  begin op_a = pose_reg[4]; op_b = p_reg[1]; first = 1'b0; last = 1'b0; end
            6'd5:  begin op_a = pose_reg[5]; op_b = p_reg[2]; first = 1'b0; dst = D_PC1; end
            6'd6:  begin op_a = pose_reg[6]; op_b = p_reg[0]; init_w = pose_reg[11]; last = 1'b0; end
            6'd7:  begin op_a = pose_reg[7]; op_b = p_reg[1]; first = 1'b0; last = 1'b0; end
            6'd8:  begin op_a = pose_reg[8]; op_b = p_reg[2]; first = 1'b0; dst = D_PC2; end
            6'd9:  begin op_a = fx_w;    op_b = xz_reg; dst = D_FXZ; end
            6'd10: begin op_a = fy_w;    op_b = yz_reg; dst = D_FYY; end
            6'd11: begin op_a = fx_w;    op_b = iz_reg; dst = D_M0; end
            6'd12: begin op_a = fxz_reg; op_b = iz_reg; dst = D_U3; end
            6'd13: begin op_a = fxz_reg; op_b = yz_reg; dst = D_U4; end
            6'd14: begin op_a = fxz_reg; op_b = xz_reg; dst = D_M1; end
            6'd15: begin op_a = fx_w;    op_b = yz_reg; dst = D_U6; end
            6'd16: begin op_a = fy_w;    op_b = iz_reg; dst = D_M2; end
            6'd17: begin op_a = fyy_reg; op_b = iz_reg; dst = D_V3; end
            6'd18: begin op_a = fyy_reg; op_b = yz_reg; dst = D_M3; end
            6'd19: begin op_a = fyy_reg; op_b = xz_reg; dst = D_M4; end
            6'd20: begin op_a = fy_w;    op_b = xz_reg; dst = D_M5; end
            6'd21: begin op_a = u_reg[1]; op_b = pose_reg[0]; last = 1'b0; end
            6'd22: begin op_a = u_reg[2]; op_b = pose_reg[3]; first = 1'b0; last = 1'b0; end
            6'd23: begin op_a = u_reg[3]; op_b = pose_reg[6]; first = 1'b0; dst = D_U7; end
            6'd24: begin op_a = u_reg[1]; op_b = pose_reg[1]; last = 1'b0; end
            6'd25: begin op_a = u_reg[2]; op_b = pose_reg[4]; first = 1'b0; last = 1'b0; end
            6'd26: begin op_a = u_reg[3]; op_b = pose_reg[7]; first = 1'b0; dst = D_U8; end
            6'd27: begin op_a = u_reg[1]; op_b = pose_reg[2]; last = 1'b0; end
            6'd28: begin op_a = u_reg[2]; op_b = pose_reg[5]; first = 1'b0; last = 1'b0; end
            6'd29: begin op_a = u_reg[3]; op_b = pose_reg[8]; first = 1'b0; dst = D_U9; end
            6'd30: begin op_a = v_reg[1]; op_b = pose_reg[0]; last = 1'b0; end
            6'd31: begin op_a = v_reg[2]; op_b = pose_reg[3]; first = 1'b0; last = 1'b0; end
            6'd32: begin op_a = v_reg[3]; op_b = pose_reg[6]; first = 1'b0; dst = D_V7; end
            6'd33: begin op_a = v_reg[1]; op_b = pose_reg[1]; last = 1'b0; end
            6'd34: begin op_a = v_reg[2]; op_b = pose_reg[4]; first = 1'b0; last = 1'b0; end
            6'd35: begin op_a = v_reg[3]; op_b = pose_reg[7]; first = 1'b0; dst = D_V8; end
            6'd36: begin op_a = v_reg[1]; op_b = pose_reg[2]; last = 1'b0; end
            6'd37: begin op_a = v_reg[2]; op_b = pose_reg[5]; first = 1'b0; last = 1'b0; end
            6'd38: begin op_a = v_reg[3]; op_b = pose_reg[8]; first = 1'b0; dst = D_V9; end
            default: begin first = 1'b1; end
        endcase
    end

    // Floor of the scaled product: arithmetic shift keeps the floor for negatives.
    assign prod    = (64'(op_a) * 64'(op_b)) >>> FRAC_BITS;
    assign acc_sum = (first ? 64'(init_w) : acc_reg) + prod;
    assign acc_sat = sat64(acc_sum);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (q_valid && (q_item.action == ACTION_PROJECT))
                begin
                    state_next = BS_MAC;
                end
            end
            BS_MAC:
            begin
                if (step_reg == STEP_W'(8))
                begin
                    state_next = BS_CHK;
                end
                else if (step_reg == STEP_W'(20))
                begin
                    state_next = BS_POST;
                end
                else if (step_reg == STEP_W'(38))
                begin
                    state_next = BS_HAND;
                end
            end
            BS_CHK:
            begin
                state_next = (pc_reg[2] <= 0) ? BS_HAND : BS_DIV;
            end
            BS_DIV:
            begin
                if (div_done && (div_sel_reg == 2'd2))
                begin
                    state_next = BS_MAC;
                end
            end
            BS_POST:
            begin
                state_next = BS_MAC;
            end
            BS_HAND:
            begin
                if (out_free)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == BS_IDLE);
        mac_en    = (state_reg == BS_MAC);
        div_start = (state_reg == BS_DIV) && !div_wait_reg;
        hand.load = (state_reg == BS_HAND) && out_free;
        hand.rows.inv = inv_reg;
        for (int i = 0; i < ROW_FIELDS; i++)
        begin
            hand.rows.u[i] = u_reg[i];
            hand.rows.v[i] = v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BS_IDLE;
            step_reg     <= '0;
            div_sel_reg  <= '0;
            div_wait_reg <= 1'b0;
            fx_reg       <= '0;
            fy_reg       <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            for (int i = 0; i < POSE_WORDS; i++)
            begin
                pose_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FOCAL_X:  fx_reg <= cfg_data;
                    REG_FOCAL_Y:  fy_reg <= cfg_data;
                    REG_CENTER_X: cx_reg <= cfg_data;
                    REG_CENTER_Y: cy_reg <= cfg_data;
                    default:      fx_reg <= fx_reg;
                endcase
            end
            if (q_valid && q_ready)
            begin
                step_reg    <= '0;
                div_sel_reg <= '0;
                if ((q_item.action == ACTION_LOAD) &&
                    (q_item.pose_index < 4'(POSE_WORDS)))
                begin
                    pose_reg[q_item.pose_index] <= q_item.pose_value;
                end
            end
            if (mac_en)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (div_start)
            begin
                div_wait_reg <= 1'b1;
            end
            if (div_done)
            begin
                div_wait_reg <= 1'b0;
                div_sel_reg  <= div_sel_reg + 1'b1;
            end
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready && (q_item.action == ACTION_PROJECT))
        begin
            p_reg[0] <= q_item.point_x;
            p_reg[1] <= q_item.point_y;
            p_reg[2] <= q_item.point_z;
            mu_reg   <= q_item.meas_u;
            mv_reg   <= q_item.meas_v;
            inv_reg  <= 1'b0;
        end
        if (mac_en)
        begin
            acc_reg <= acc_sum;
            if (last)
            begin
                case (dst)
                    D_PC0: pc_reg[0] <= acc_sat;
                    D_PC1: pc_reg[1] <= acc_sat;
                    D_PC2: pc_reg[2] <= acc_sat;
                    D_FXZ: fxz_reg   <= acc_sat;
                    D_FYY: fyy_reg   <= acc_sat;
                    D_M0:  m_reg[0]  <= acc_sat;
                    D_M1:  m_reg[1]  <= acc_sat;
                    D_M2:  m_reg[2]  <= acc_sat;
                    D_M3:  m_reg[3]  <= acc_sat;
                    D_M4:  m_reg[4]  <= acc_sat;
                    D_M5:  m_reg[5]  <= acc_sat;
                    D_U3:  u_reg[3]  <= acc_sat;
                    D_U4:  u_reg[4]  <= acc_sat;
                    D_U6:  u_reg[6]  <= acc_sat;
                    D_V3:  v_reg[3]  <= acc_sat;
                    D_U7:  u_reg[7]  <= acc_sat;
                    D_U8:  u_reg[8]  <= acc_sat;
                    D_U9:  u_reg[9]  <= acc_sat;
                    D_V7:  v_reg[7]  <= acc_sat;
                    D_V8:  v_reg[8]  <= acc_sat;
                    D_V9:  v_reg[9]  <= acc_sat;
                    default:
                    begin
                    end
                endcase
            end
        end
        if ((state_reg == BS_CHK) && (pc_reg[2] <= 0))
        begin
            inv_reg <= 1'b1;
            for (int i = 0; i < ROW_FIELDS; i++)
            begin
                u_reg[i] <= '0;
                v_reg[i] <= '0;
            end
        end
        if (div_done)
        begin
            case (div_sel_reg)
                2'd0:    xz_reg <= div_quo;
                2'd1:    yz_reg <= div_quo;
                default: iz_reg <= div_quo;
            endcase
        end
        if (state_reg == BS_POST)
        begin
            u_reg[0] <= sat64(64'(mu_reg) - (64'(fxz_reg) + 64'({1'b0, cx_reg})));
            u_reg[1] <= sat64(-64'(m_reg[0]));
            u_reg[2] <= '0;
            u_reg[5] <= sat64(-64'(fx_w) - 64'(m_reg[1]));
            v_reg[0] <= sat64(64'(mv_reg) - (64'(fyy_reg) + 64'({1'b0, cy_reg})));
            v_reg[1] <= '0;
            v_reg[2] <= sat64(-64'(m_reg[2]));
            v_reg[4] <= sat64(64'(fy_w) + 64'(m_reg[3]));
            v_reg[5] <= sat64(-64'(m_reg[4]));
            v_reg[6] <= sat64(-64'(m_reg[5]));
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rej_out.sv]
// Result buffer: hold one row pair and send the u row, then the v row.
`default_nettype none

module rej_out (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rej_pkg::hand_t                   hand,
    output logic                                  out_free,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [rej_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import rej_pkg::*;

    out_state_t state_reg;
    out_state_t state_next;
    rows_t      rows_reg;
    logic       beat;

    assign beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            OS_EMPTY:
            begin
                if (hand.load)
                begin
                    state_next = OS_U;
                end
            end
            OS_U:
            begin
                if (beat)
                begin
                    state_next = OS_V;
                end
            end
            OS_V:
            begin
                if (hand.load)
                begin
                    state_next = OS_U;
                end
                else if (beat)
                begin
                    state_next = OS_EMPTY;
                end
            end
            default:
            begin
                state_next = OS_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        out_free      = (state_reg == OS_EMPTY) || ((state_reg == OS_V) && m_axis_tready);
        m_axis_tvalid = (state_reg != OS_EMPTY);
        m_axis_tlast  = (state_reg == OS_V);
        m_axis_tuser  = rows_reg.inv;
        for (int i = 0; i < ROW_FIELDS; i++)
        begin
            m_axis_tdata[i*DATA_W +: DATA_W] = (state_reg == OS_V) ? rows_reg.v[i]
                                                                     : rows_reg.u[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= OS_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hand.load)
        begin
            rows_reg <= hand.rows;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/reprojection_error_jacobian_unit.sv]
// Top level of the pinhole reprojection residual and Jacobian unit.
`default_nettype none

`include "reprojection_error_jacobian_unit_defines.svh"

// Input beats (tuser low: write one pose word; tuser high: project a point) enter a
// four-deep queue, so the input side keeps taking beats while the sequencer works
// and while finished rows wait at the output. A pose write leaves the queue as soon
// as the sequencer is idle. A project beat runs on one shared 32x32 Q16.16
// multiply-accumulate unit and one radix-2 divider that retires one quotient bit
// per cycle: it accepts the beat, forms the camera point, checks the depth, runs
// three divides, 12 scalar products, the sums, 18 point-column products and the
// hand-off. A point at non-positive depth skips the divides and all later products.
// Each project beat yields two output beats, the u row (tlast low) and then the v
// row (tlast high); the rows sit in their own buffer so the next item starts while
// they drain. Write configuration only while no item is queued or in flight; a
// write takes effect at once.
module reprojection_error_jacobian_unit
    import rej_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration: 0 focal_x, 1 focal_y, 2 center_x, 3 center_y
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // pose_index[3:0], pose_value[35:4], point_x[67:36], point_y[99:68],
    // point_z[131:100], meas_u[163:132], meas_v[195:164], zero pad
    input  wire logic [IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  wire logic                      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // residual, jac_tx, jac_ty, jac_tz, jac_rx, jac_ry, jac_rz, jac_px, jac_py,
    // jac_pz, 32 bits each from the lowest bit up
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata,
    // depth_invalid
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;
    logic  out_free;
    hand_t hand;

    // Queue between the input side and the sequencer.
    rej_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    // Pose store, camera registers and the arithmetic sequencer.
    rej_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_free  (out_free),
        .hand      (hand)
    );

    // Row buffer: hold the pair until both beats are taken.
    rej_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .hand          (hand),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A row pair is handed over only when the buffer can take it.
    `REJ_ASSERT_NOW(a_load_free, hand.load, out_free)
    // The u row is always followed by its v row.
    `REJ_ASSERT_NEXT(a_u_then_v, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        m_axis_tvalid && m_axis_tlast)
    // A row flagged for bad depth carries only zeros.
    `REJ_ASSERT_NOW(a_inv_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the reprojection residual and Jacobian unit.
`default_nettype none

module testbench;
    import rej_pkg::*;

    // Watchdog: cycles with no beat on either side before giving up. Covers the
    // deliberate receiver hold-off plus a full queue of slow divides.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int MAX_GAP        = 18;
    localparam longint ONE_Q      = 64'sd1 <<< FRAC_BITS;

    // One expected output row.
    typedef struct {
        word_t f[ROW_FIELDS];
        logic  inv;
        logic  lst;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_index = REG_FOCAL_X;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = ACTION_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // Predictor state: camera registers and the twelve pose words.
    longint cam_fx, cam_fy, cam_cx, cam_cy;
    word_t  pose_w[POSE_WORDS];
    row_t   expected_rows[$];

    int  items_sent;
    int  rows_checked;
    int  invalid_rows;
    int  mismatches;
    int  idle_cycles;
    bit  tx_steady;
    bit  rx_steady;
    bit  hold_req;
    int  stall_left;

    string field_names[ROW_FIELDS] = '{"residual", "jac_tx", "jac_ty", "jac_tz",
        "jac_rx", "jac_ry", "jac_rz", "jac_px", "jac_py", "jac_pz"};

    reprojection_error_jacobian_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint clip(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    // Fixed-point product, floored, then clipped.
    function automatic longint qmul(input longint a, input longint b);
        return clip((a * b) >>> FRAC_BITS);
    endfunction

    // Fixed-point quotient, truncated toward zero; b is always positive here.
    function automatic longint qdiv(input longint a, input longint b);
        return clip((a * ONE_Q) / b);
    endfunction

    // Work out both rows of one projection and queue them.
    task automatic predict_rows(input item_t it);
        longint pt[3];
        longint pc[3];
        longint jr[2][10];
        longint acc, xz, yz, iz, fxz, fyy;
        row_t   row;
        int     i, k, r;
        pt[0] = longint'(it.point_x);
        pt[1] = longint'(it.point_y);
        pt[2] = longint'(it.point_z);
        for (i = 0; i < 3; i++)
        begin
            acc = longint'(pose_w[9 + i]);
            for (k = 0; k < 3; k++)
            begin
                acc += (longint'(pose_w[i * 3 + k]) * pt[k]) >>> FRAC_BITS;
            end
            pc[i] = clip(acc);
        end
        // Point at or behind the camera: zero rows, flag set.
        if (pc[2] <= 0)
        begin
            for (r = 0; r < 2; r++)
            begin
                foreach (row.f[k])
                begin
                    row.f[k] = '0;
                end
                row.inv = 1'b1;
                row.lst = r[0];
                expected_rows.push_back(row);
            end
            return;
        end
        xz  = qdiv(pc[0], pc[2]);
        yz  = qdiv(pc[1], pc[2]);
        iz  = qdiv(ONE_Q, pc[2]);
        fxz = qmul(cam_fx, xz);
        fyy = qmul(cam_fy, yz);

        jr[0][0] = clip(longint'(it.meas_u) - (fxz + cam_cx));
        jr[0][1] = clip(-qmul(cam_fx, iz));
        jr[0][2] = 0;
        jr[0][3] = qmul(fxz, iz);
        jr[0][4] = qmul(fxz, yz);
        jr[0][5] = clip(-cam_fx - qmul(fxz, xz));
        jr[0][6] = qmul(cam_fx, yz);

        jr[1][0] = clip(longint'(it.meas_v) - (fyy + cam_cy));
        jr[1][1] = 0;
        jr[1][2] = clip(-qmul(cam_fy, iz));
        jr[1][3] = qmul(fyy, iz);
        jr[1][4] = clip(cam_fy + qmul(fyy, yz));
        jr[1][5] = clip(-qmul(fyy, xz));
        jr[1][6] = clip(-qmul(cam_fy, xz));

        for (r = 0; r < 2; r++)
        begin
            // Point columns: translation columns times the rotation.
            for (k = 0; k < 3; k++)
            begin
                acc = 0;
                for (i = 0; i < 3; i++)
                begin
                    acc += (jr[r][1 + i] * longint'(pose_w[i * 3 + k])) >>> FRAC_BITS;
                end
                jr[r][7 + k] = clip(acc);
            end
            for (k = 0; k < ROW_FIELDS; k++)
            begin
                row.f[k] = word_t'(jr[r][k]);
            end
            row.inv = 1'b0;
            row.lst = r[0];
            expected_rows.push_back(row);
        end
    endtask

    // ---------------------------------------------------------------- drivers

    // Drive one input beat, after a random gap unless tx_steady is set, and hold it until taken.
    task automatic send_item(input item_t it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= IN_TDATA_W'({it.meas_v, it.meas_u, it.point_z, it.point_y,
                                      it.point_x, it.pose_value, it.pose_index});
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (it.action == ACTION_LOAD)
        begin
            // Indexes past the pose words are dropped by the block.
            if (it.pose_index < POSE_WORDS)
            begin
                pose_w[it.pose_index] = it.pose_value;
            end
        end
        else
        begin
            predict_rows(it);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FOCAL_X:  cam_fx = longint'(val);
            REG_FOCAL_Y:  cam_fy = longint'(val);
            REG_CENTER_X: cam_cx = longint'(val);
            default:      cam_cy = longint'(val);
        endcase
    endtask

    task automatic set_camera(input logic [CFG_W-1:0] fx, input logic [CFG_W-1:0] fy,
                              input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
    endtask

    // Drop the input, wait for every row, then let trailing loads retire.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- item makers

    function automatic word_t q_between(input int lo, input int hi);
        return word_t'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Half plain random words, half the extremes and zero.
    function automatic word_t any_word();
        word_t w;
        case ($urandom_range(0, 5))
            0:       w = SAT_MAX;
            1:       w = SAT_MIN;
            2:       w = '0;
            default: w = word_t'($urandom);
        endcase
        return w;
    endfunction

    function automatic item_t load_item(input logic [3:0] idx, input word_t val);
        item_t it;
        it.action     = ACTION_LOAD;
        it.pose_index = idx;
        it.pose_value = val;
        it.point_x    = word_t'($urandom);
        it.point_y    = word_t'($urandom);
        it.point_z    = word_t'($urandom);
        it.meas_u     = word_t'($urandom);
        it.meas_v     = word_t'($urandom);
        return it;
    endfunction

    function automatic item_t project_item(input word_t px, input word_t py,
                                           input word_t pz, input word_t mu,
                                           input word_t mv);
        item_t it;
        it.action     = ACTION_PROJECT;
        it.pose_index = 4'($urandom);
        it.pose_value = word_t'($urandom);
        it.point_x    = px;
        it.point_y    = py;
        it.point_z    = pz;
        it.meas_u     = mu;
        it.meas_v     = mv;
        return it;
    endfunction

    // Plausible pose word: rotation within +-1.0, translation within +-10.0.
    function automatic word_t pose_word(input int idx);
        return (idx < 9) ? q_between(-65536, 65536) : q_between(-655360, 655360);
    endfunction

    // Plausible observation; depth sometimes lands behind the camera.
    function automatic item_t plausible_projection();
        return project_item(q_between(-1310720, 1310720), q_between(-1310720, 1310720),
                            q_between(-131072, 2621440), q_between(0, 52428800),
                            q_between(0, 52428800));
    endfunction

    function automatic logic [CFG_W-1:0] focal_q();
        return CFG_W'($urandom_range(200 * 65536, 1000 * 65536));
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at row %0d, %s: expected %h, got %h",
                     rows_checked, what, want, got);
        end
    endtask

    // Compare every output beat with the oldest queued row.
    always @(posedge clk)
    begin : row_check
        row_t want;
        int   k;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_rows.size() == 0)
            begin
                flag_mismatch("unexpected row", '0, m_axis_tdata[31:0]);
            end
            else
            begin
                want = expected_rows.pop_front();
                for (k = 0; k < ROW_FIELDS; k++)
                begin
                    if (m_axis_tdata[k * DATA_W +: DATA_W] !== want.f[k])
                    begin
                        flag_mismatch(field_names[k], want.f[k],
                                      m_axis_tdata[k * DATA_W +: DATA_W]);
                    end
                end
                if (m_axis_tuser !== want.inv)
                begin
                    flag_mismatch("depth_invalid", 32'(want.inv), 32'(m_axis_tuser));
                end
                if (m_axis_tlast !== want.lst)
                begin
                    flag_mismatch("last", 32'(want.lst), 32'(m_axis_tlast));
                end
                if (want.inv)
                begin
                    invalid_rows++;
                end
            end
            rows_checked++;
        end
    end

    // Receiver: random stall after each beat, or one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            stall_left = HOLD_CYCLES;
            hold_req   = 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            stall_left = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d rows outstanding",
                     idle_cycles, expected_rows.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Everything zero after reset: depth is zero, so both rows are flagged.
    task automatic test_reset_state();
        send_item(project_item(32'sh00010000, 32'sh00020000, 32'sh00030000, '0, '0));
        settle();
    endtask

    // Identity pose, typical camera, then depth corners, extremes and dropped loads.
    task automatic test_directed();
        set_camera(CFG_W'(400 * 65536), CFG_W'(400 * 65536),
                   CFG_W'(320 * 65536), CFG_W'(240 * 65536));
        send_item(load_item(4'd0, 32'sh00010000));
        send_item(load_item(4'd4, 32'sh00010000));
        send_item(load_item(4'd8, 32'sh00010000));
        send_item(load_item(4'd11, 32'sh00050000));
        send_item(project_item(32'sh00010000, 32'sh00020000, 32'sh000a0000,
                               32'sh015e0000, 32'sh01040000));
        // behind the camera, then exactly on the image plane's zero depth
        send_item(project_item(32'sh00010000, 32'sh00010000, -32'sh00140000, '0, '0));
        send_item(project_item('0, '0, -32'sh00050000, '0, '0));
        // depth just above zero: quotients blow up and clip
        send_item(project_item(32'sh00640000, -32'sh00640000, -32'sh0004ffff,
                               SAT_MIN, SAT_MAX));
        send_item(project_item(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN));
        send_item(project_item(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX));
        // loads past the last pose word must be ignored
        send_item(load_item(4'd12, SAT_MAX));
        send_item(load_item(4'd13, SAT_MIN));
        send_item(load_item(4'd14, 32'sh12345678));
        send_item(load_item(4'd15, -32'sh1));
        send_item(project_item(32'sh00010000, 32'sh00020000, 32'sh000a0000,
                               32'sh015e0000, 32'sh01040000));
        // extreme rotation words
        send_item(load_item(4'd1, SAT_MAX));
        send_item(load_item(4'd3, SAT_MIN));
        send_item(project_item(32'sh00030000, -32'sh00020000, 32'sh00080000,
                               32'sh00100000, 32'sh00200000));
        settle();
    endtask

    // One burst: mostly a pose update followed by observations, sometimes noise.
    task automatic run_burst();
        int n, i;
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) != 0)
        begin
            n = $urandom_range(0, 1) ? POSE_WORDS : $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                if (n == POSE_WORDS)
                begin
                    send_item(load_item(4'(i), pose_word(i)));
                end
                else
                begin
                    i = i;
                    send_item(load_item(4'($urandom_range(0, POSE_WORDS - 1)),
                                        pose_word($urandom_range(0, POSE_WORDS - 1))));
                end
            end
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                send_item(plausible_projection());
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_item(load_item(4'($urandom_range(0, 15)), any_word()));
                end
                else
                begin
                    send_item(project_item(any_word(), any_word(), any_word(),
                                           any_word(), any_word()));
                end
            end
        end
    endtask

    // Four camera settings, typical to extreme, each with its share of items.
    task automatic test_random_phases();
        int phase, stop_at;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_camera(focal_q(), focal_q(), CFG_W'($urandom_range(0, 800 * 65536)),
                              CFG_W'($urandom_range(0, 800 * 65536)));
                1: set_camera('1, '1, '1, '1);
                2: set_camera('0, '0, '0, '0);
                default: set_camera(CFG_W'($urandom), CFG_W'($urandom),
                                    CFG_W'($urandom), CFG_W'($urandom));
            endcase
            stop_at = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < stop_at)
            begin
                run_burst();
            end
            settle();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Hold the receiver off while the sender keeps going, so the input stalls.
    task automatic test_backpressure();
        int i;
        set_camera(focal_q(), focal_q(), CFG_W'(320 * 65536), CFG_W'(240 * 65536));
        for (i = 0; i < POSE_WORDS; i++)
        begin
            send_item(load_item(4'(i), pose_word(i)));
        end
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        for (i = 0; i < 10; i++)
        begin
            send_item(plausible_projection());
        end
        tx_steady = 1'b0;
        // sender pauses here until every row has drained
        settle();
    endtask

    initial
    begin
        foreach (pose_w[i])
        begin
            pose_w[i] = '0;
        end
        cam_fx = 0;
        cam_fy = 0;
        cam_cx = 0;
        cam_cy = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_backpressure();
        test_random_phases();

        mismatches += expected_rows.size();
        $display("covered %0d input beats and %0d result rows (%0d at invalid depth)",
                 items_sent, rows_checked, invalid_rows);
        $display("camera settings from zero to full scale, with long output hold-off");
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
